FILE: hw/rtl/mmnb_pkg.sv
// ----------------------------------------------------------------------------
// mmnb_pkg
// Shared types and constants for the min/max normalize-to-byte core.
// ----------------------------------------------------------------------------
package mmnb_pkg;

    localparam int FRAC_BITS_DEF = 8;

    localparam int VAL_W   = 32;            // voxel value width
    localparam int PIX_W   = 8;             // pixel width
    localparam int DEN_W   = VAL_W + 1;     // max - min + eps
    localparam int DIV_W   = 42;            // 2*num + den and divisor << 9
    localparam int Q_STEPS = PIX_W + 1;     // quotient bits incl. overflow bit
    localparam int CNT_W   = 4;             // holds Q_STEPS - 1

    localparam logic ACT_MEASURE = 1'b0;
    localparam logic ACT_CONVERT = 1'b1;

    localparam logic MODE_CLAMP   = 1'b0;
    localparam logic MODE_STRETCH = 1'b1;

    // register index (byte address = 4 * index)
    localparam logic REG_MODE = 1'b0;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_DIV,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic meas;     // update running min/max from the input value
        logic load;     // latch a convert request (clamp pixel, divider operands)
        logic prep;     // build dividend and divisor
        logic step;     // one restoring division step
        logic fin;      // last step: write the stretched pixel
        logic push;     // move the pixel into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } t_dp_sts;

endpackage

FILE: hw/rtl/mmnb_ctrl.sv
// ----------------------------------------------------------------------------
// mmnb_ctrl
// Sequencer: input handshake, division step control, output push.
// ----------------------------------------------------------------------------
module mmnb_ctrl
    import mmnb_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_action,
    input  logic    i_mode,
    input  t_dp_sts i_sts,
    output logic    o_ready,
    output t_dp_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   accept;

    assign accept = i_valid && (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_action == ACT_CONVERT)) begin
                    n_state = (i_mode == MODE_STRETCH) ? S_PREP : S_WRITE;
                end
            end
            S_PREP: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_ready   = (r_state == S_IDLE);
        o_cmd     = '0;
        o_cmd.meas = accept && (i_action == ACT_MEASURE);
        o_cmd.load = accept && (i_action == ACT_CONVERT);
        o_cmd.prep = (r_state == S_PREP);
        o_cmd.step = (r_state == S_DIV);
        o_cmd.fin  = (r_state == S_DIV) && i_sts.div_last;
        o_cmd.push = (r_state == S_WRITE) && i_sts.out_free;
    end

    a_div_to_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_WRITE))
        else $error("division end did not lead to write");

    a_measure_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_ready && i_valid && i_action == ACT_MEASURE) |=> (r_state == S_IDLE))
        else $error("measure request left idle");

    a_prep_to_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PREP) |=> (r_state == S_DIV))
        else $error("operand prep did not lead to division");

endmodule

FILE: hw/rtl/mmnb_dp.sv
// ----------------------------------------------------------------------------
// mmnb_dp
// Datapath: running min/max, clamp pixel, radix-2 restoring divider,
// output register.
// ----------------------------------------------------------------------------
module mmnb_dp
    import mmnb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_dp_cmd                 i_cmd,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_first,
    input  logic                    i_ready,
    output t_dp_sts                 o_sts,
    output logic                    o_valid,
    output logic [PIX_W-1:0]        o_pixel
);

    // eps = round(0.01 * 2^FRAC_BITS), at least 1
    localparam int unsigned EPS_RAW = ((32'd1 << FRAC_BITS) + 32'd50) / 32'd100;
    localparam int unsigned EPS     = (EPS_RAW == 0) ? 1 : EPS_RAW;

    logic signed [VAL_W-1:0] r_min;
    logic signed [VAL_W-1:0] r_max;
    logic [VAL_W-1:0]        r_d;
    logic [DEN_W-1:0]        r_den;
    logic                    r_zero;
    logic [DIV_W-1:0]        r_rem;
    logic [DIV_W-1:0]        r_dsh;
    logic [Q_STEPS-1:0]      r_q;
    logic [CNT_W-1:0]        r_cnt;
    logic [PIX_W-1:0]        r_pix;
    logic                    r_out_valid;
    logic [PIX_W-1:0]        r_out_pix;

    logic [VAL_W:0]          diff_v;
    logic [VAL_W:0]          diff_hl;
    logic [DEN_W-1:0]        den;
    logic [VAL_W-1:0]        shifted;
    logic [PIX_W-1:0]        clamp_pix;
    logic                    ge;
    logic [Q_STEPS-1:0]      n_q;
    logic [PIX_W-1:0]        stretch_pix;

    assign diff_v  = {i_value[VAL_W-1], i_value} - {r_min[VAL_W-1], r_min};
    assign diff_hl = {r_max[VAL_W-1], r_max} - {r_min[VAL_W-1], r_min};
    assign den     = ((r_max > r_min) ? {1'b0, diff_hl[VAL_W-1:0]} : '0) + DEN_W'(EPS);

    // clamp mode: drop the fraction, saturate to 0..255
    assign shifted   = VAL_W'($unsigned(i_value) >> FRAC_BITS);
    assign clamp_pix = i_value[VAL_W-1] ? '0 :
                       (|shifted[VAL_W-1:PIX_W]) ? '1 : shifted[PIX_W-1:0];

    assign ge          = (r_rem >= r_dsh);
    assign n_q         = {r_q[Q_STEPS-2:0], ge};
    assign stretch_pix = r_zero ? '0 : (n_q[Q_STEPS-1] ? '1 : n_q[PIX_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= '0;
        end else if (i_cmd.meas) begin
            if (i_first) begin
                r_min <= i_value;
                r_max <= i_value;
            end else begin
                if (i_value < r_min) r_min <= i_value;
                if (i_value > r_max) r_max <= i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_d    <= diff_v[VAL_W-1:0];
            r_zero <= (i_value <= r_min);
            r_den  <= den;
            r_pix  <= clamp_pix;
        end
        if (i_cmd.prep) begin
            // dividend 2*255*d + den, divisor 2*den aligned for 9 quotient bits
            r_rem <= (DIV_W'(r_d) << 9) - (DIV_W'(r_d) << 1) + DIV_W'(r_den);
            r_dsh <= DIV_W'(r_den) << (PIX_W + 1);
            r_q   <= '0;
            r_cnt <= CNT_W'(Q_STEPS - 1);
        end
        if (i_cmd.step) begin
            if (ge) r_rem <= r_rem - r_dsh;
            r_dsh <= r_dsh >> 1;
            r_q   <= n_q;
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.fin) begin
            r_pix <= stretch_pix;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_pix <= r_pix;
        end
    end

    assign o_sts.div_last = (r_cnt == '0);
    assign o_sts.out_free = !r_out_valid || i_ready;
    assign o_valid        = r_out_valid;
    assign o_pixel        = r_out_pix;

    a_min_le_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_cmd.meas) |-> (r_min <= r_max))
        else $error("running min above running max");

    a_below_min_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.fin && r_zero) |=> (r_pix == '0))
        else $error("value at or below min gave nonzero pixel");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_pixel)))
        else $error("pending pixel dropped or changed while stalled");

endmodule

FILE: hw/rtl/minmax_normalize_to_byte_core.sv
// ----------------------------------------------------------------------------
// minmax_normalize_to_byte_core
// Signed fixed-point voxel values to 8-bit pixels, clamp or min/max stretch.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 payload
//  input     in         i_valid / o_ready         i_action, i_value, i_first
//  output    out        o_valid / i_ready         o_pixel
//  config    in         psel/penable/pwrite/pready paddr, pwdata, prdata (mode)
//
//  Measure request: updates running min/max, no pixel.
//  Convert, clamp mode: accept, then write to output register.
//  Convert, stretch mode: accept, operand prep, 9 radix-2 restoring
//  division steps, write.
//  Reset (synchronous, active low) clears mode, min, max and all control.
//  A new request is taken while a pixel waits in the output register;
//  a pending pixel only stalls the next convert at its write cycle.
// ----------------------------------------------------------------------------
module minmax_normalize_to_byte_core
    import mmnb_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // input request channel
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic                    i_action,
    input  logic signed [VAL_W-1:0] i_value,
    input  logic                    i_first,
    // pixel channel
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic [PIX_W-1:0]        o_pixel,
    // configuration port
    input  logic                    psel,
    input  logic                    penable,
    input  logic                    pwrite,
    input  logic [2:0]              paddr,
    input  logic [31:0]             pwdata,
    output logic [31:0]             prdata,
    output logic                    pready
);

    logic    r_mode;
    t_dp_cmd cmd;
    t_dp_sts sts;

    // mode register at byte address 0; paddr[2] selects the register slot
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_CLAMP;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_MODE)) begin
            r_mode <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_MODE) ? {31'b0, r_mode} : '0;

    mmnb_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .i_action (i_action),
        .i_mode   (r_mode),
        .i_sts    (sts),
        .o_ready  (o_ready),
        .o_cmd    (cmd)
    );

    mmnb_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_value  (i_value),
        .i_first  (i_first),
        .i_ready  (i_ready),
        .o_sts    (sts),
        .o_valid  (o_valid),
        .o_pixel  (o_pixel)
    );

endmodule

FILE: test/minmax_normalize_to_byte_core_test.sv
// ----------------------------------------------------------------------------
// minmax_normalize_to_byte_core_test
// Self-checking regression for the min/max normalize-to-byte core. Requests
// go in over valid/ready, and each is scored by a cycle-free pixel predictor
// that keeps its own mode and running min/max. Every pixel is compared
// against the oldest pending prediction. Both handshakes idle in random
// bursts, and the mode register is written over APB only while the core is
// quiet.
// ----------------------------------------------------------------------------
module minmax_normalize_to_byte_core_test;
    import mmnb_pkg::*;

    // Allow some margin after the last pixel before touching the mode register
    // or ending the run.
    localparam int SETTLE_CYCLES = 20;
    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int HANG_LIMIT    = 2000;

    // eps = round(0.01 * 2^FRAC_BITS), never below one raw code
    localparam longint unsigned EPS_RAW = ((64'd1 << FRAC_BITS_DEF) + 64'd50) / 64'd100;
    localparam longint unsigned EPS_Q   = (EPS_RAW == 0) ? 64'd1 : EPS_RAW;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic                    i_action;
    logic signed [VAL_W-1:0] i_value;
    logic                    i_first;
    logic                    o_valid;
    logic                    i_ready;
    logic [PIX_W-1:0]        o_pixel;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [2:0]              paddr;
    logic [31:0]             pwdata;
    logic [31:0]             prdata;
    logic                    pready;

    // Predictor state, mirrors what the core should hold
    logic                    mode_q;
    logic signed [VAL_W-1:0] range_lo;
    logic signed [VAL_W-1:0] range_hi;
    logic [PIX_W-1:0]        pixel_q[$];     // predicted pixels, oldest first

    bit idle_on;                             // random idling on both channels
    int fails;
    int n_measure, n_clamp, n_stretch, n_checked, n_mode_writes;
    int hang_cnt;

    minmax_normalize_to_byte_core #(
        .FRAC_BITS(FRAC_BITS_DEF)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_action (i_action),
        .i_value  (i_value),
        .i_first  (i_first),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_pixel  (o_pixel),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Pixel predictor
    // ------------------------------------------------------------------

    // clamp: negative -> 0, drop the fraction, saturate at 255
    function automatic logic [PIX_W-1:0] clamp_to_pixel(input logic signed [VAL_W-1:0] v);
        logic [VAL_W-1:0] whole;
        if (v < 0)
            return '0;
        whole = v >> FRAC_BITS_DEF;
        return (whole > 255) ? 8'hFF : whole[PIX_W-1:0];
    endfunction

    // stretch: round((v-min)*255 / (max-min+eps)), half up, saturate at 255.
    // Done in 64 bits; (v-min)*255 fits in 40.
    function automatic logic [PIX_W-1:0] stretch_to_pixel(input logic signed [VAL_W-1:0] v);
        longint dv, lo, hi;
        longint unsigned num, den, q;
        dv = v;
        lo = range_lo;
        hi = range_hi;
        if (dv <= lo)
            return '0;
        num = (dv - lo) * 255;
        den = (hi > lo) ? (hi - lo) : 0;
        den = den + EPS_Q;
        q   = (2 * num + den) / (2 * den);
        return (q > 255) ? 8'hFF : q[PIX_W-1:0];
    endfunction

    // Apply one accepted request: measure updates the range in either mode,
    // convert queues a pixel. First is ignored on converts.
    function automatic void apply_request(input logic act, input logic signed [VAL_W-1:0] v,
                                          input logic restart);
        if (act == ACT_MEASURE) begin
            n_measure++;
            if (restart) begin
                range_lo = v;
                range_hi = v;
            end else begin
                if (v < range_lo)
                    range_lo = v;
                if (v > range_hi)
                    range_hi = v;
            end
        end else if (mode_q == MODE_STRETCH) begin
            n_stretch++;
            pixel_q.push_back(stretch_to_pixel(v));
        end else begin
            n_clamp++;
            pixel_q.push_back(clamp_to_pixel(v));
        end
    endfunction

    // ------------------------------------------------------------------
    // Pixel checker: score every pixel that leaves the core
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic [PIX_W-1:0] want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pixel_q.size() == 0) begin
                $error("unexpected pixel: expected none, actual %0d", o_pixel);
                fails++;
            end else begin
                want = pixel_q.pop_front();
                n_checked++;
                if (o_pixel !== want) begin
                    $error("pixel mismatch: expected %0d, actual %0d", want, o_pixel);
                    fails++;
                end
            end
        end
    end

    // Receiver: ready drops in random bursts while idling is on
    initial begin
        int n;
        i_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (idle_on && $urandom_range(0, 5) == 0) begin
                i_ready <= 1'b0;
                n = $urandom_range(1, 4);
                repeat (n - 1) @(negedge i_clk);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Watchdog: no transfer on either channel for too long means a hang
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            hang_cnt <= 0;
        else
            hang_cnt <= hang_cnt + 1;
        if (hang_cnt >= HANG_LIMIT) begin
            $display("minmax_normalize_to_byte_core regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared driving tasks
    // ------------------------------------------------------------------

    // Send one request. Valid is left high after acceptance so the next call
    // can stream back to back; release_input() drops it before any pause.
    task automatic send_request(input logic act, input logic signed [VAL_W-1:0] v,
                                input logic restart);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 3) == 0)
            gap = $urandom_range(1, 4);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid  <= 1'b1;
        i_action <= act;
        i_value  <= v;
        i_first  <= restart;
        do @(posedge i_clk); while (!o_ready);
        apply_request(act, v, restart);
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    // Sender holds off until every predicted pixel has come back
    task automatic wait_drained();
        release_input();
        while (pixel_q.size() != 0) @(posedge i_clk);
    endtask

    // APB write of the mode register, only with the core quiet. Measures
    // leave no pixel to wait for, so let the pipeline settle as well.
    task automatic set_mode(input logic m);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MODE, 2'b00};
        pwdata  <= {31'd0, m};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        mode_q = m;
        n_mode_writes++;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Mix of full-range, clamp-window, small and corner values
    function automatic logic signed [VAL_W-1:0] rand_voxel();
        logic signed [VAL_W-1:0] v;
        case ($urandom_range(0, 4))
            0: v = $urandom;
            1: v = $urandom_range(0, 32'h0001_1000);
            2: begin
                v = $urandom_range(0, 32'h0000_4000);
                v = -v;
            end
            3: v = $urandom_range(0, 511) - 256;
            default: begin
                case ($urandom_range(0, 5))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = 0;
                    3: v = -1;
                    4: v = 32'sh0000_FF00;
                    default: v = 32'sh0001_0000;
                endcase
            end
        endcase
        return v;
    endfunction

    // One volume through the stretch flow: measure pass, then convert pass
    // over the same values. Now and then the range is not restarted, a stray
    // convert slips in between the passes, or the convert pass is cut short.
    task automatic run_volume(input int n, input logic signed [VAL_W-1:0] base,
                              input int unsigned span);
        logic signed [VAL_W-1:0] vox[$];
        bit restart;
        int stop;
        restart = ($urandom_range(0, 9) != 0);
        stop    = ($urandom_range(0, 7) == 0) ? $urandom_range(0, n) : n;
        for (int i = 0; i < n; i++)
            vox.push_back(base + $urandom_range(0, span));
        for (int i = 0; i < n; i++)
            send_request(ACT_MEASURE, vox[i], (i == 0) && restart);
        if ($urandom_range(0, 5) == 0)
            send_request(ACT_CONVERT, rand_voxel(), 1'($urandom_range(0, 1)));
        for (int i = 0; i < stop; i++)
            send_request(ACT_CONVERT, vox[i], $urandom_range(0, 7) == 0);
    endtask

    task automatic random_volume();
        logic signed [VAL_W-1:0] base;
        int unsigned span;
        case ($urandom_range(0, 2))
            0: base = $urandom;
            1: base = $urandom_range(0, 8192) - 4096;
            default: begin
                base = $urandom_range(0, 1 << 20);
                base = -base;
            end
        endcase
        case ($urandom_range(0, 7))
            0: span = 0;
            1: span = $urandom;
            default: span = 1 << $urandom_range(0, 24);
        endcase
        run_volume($urandom_range(1, 10), base, span);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Stretch straight out of reset: min = max = 0, den is eps alone
    task automatic test_stretch_from_reset();
        set_mode(MODE_STRETCH);
        send_request(ACT_CONVERT, 0, 1'b0);
        send_request(ACT_CONVERT, 1, 1'b0);
        send_request(ACT_CONVERT, 2, 1'b0);
        send_request(ACT_CONVERT, 100, 1'b0);
        send_request(ACT_CONVERT, 32'sh7FFF_FFFF, 1'b0);
        send_request(ACT_CONVERT, 32'sh8000_0000, 1'b0);
    endtask

    // Clamp edges: negative, fraction drop, 256.0 and above, extremes, and
    // first on a convert being ignored. Measures here feed the next test.
    task automatic test_clamp_corners();
        set_mode(MODE_CLAMP);
        send_request(ACT_CONVERT, 0, 1'b0);
        send_request(ACT_CONVERT, -1, 1'b0);
        send_request(ACT_CONVERT, 32'sh0000_0180, 1'b0);
        send_request(ACT_CONVERT, 32'sh0000_FFFF, 1'b0);
        send_request(ACT_CONVERT, 32'sh0001_0000, 1'b0);
        send_request(ACT_CONVERT, 32'sh7FFF_FFFF, 1'b0);
        send_request(ACT_CONVERT, 32'sh8000_0000, 1'b0);
        send_request(ACT_CONVERT, 32'sh0000_1234, 1'b1);
        send_request(ACT_MEASURE, -1000, 1'b1);
        send_request(ACT_MEASURE, 5000, 1'b0);
        send_request(ACT_CONVERT, 300, 1'b0);
    endtask

    // Stretch edges: full signed range, below/at min, min == max, saturation
    task automatic test_stretch_corners();
        set_mode(MODE_STRETCH);
        send_request(ACT_CONVERT, 2000, 1'b0);          // range from the clamp test
        send_request(ACT_MEASURE, 32'sh8000_0000, 1'b1);
        send_request(ACT_MEASURE, 32'sh7FFF_FFFF, 1'b0);
        send_request(ACT_CONVERT, 32'sh7FFF_FFFF, 1'b0);
        send_request(ACT_CONVERT, 32'sh8000_0000, 1'b0);
        send_request(ACT_CONVERT, 0, 1'b0);
        send_request(ACT_MEASURE, 100, 1'b1);
        send_request(ACT_CONVERT, 100, 1'b0);
        send_request(ACT_CONVERT, 99, 1'b0);
        send_request(ACT_CONVERT, 101, 1'b0);
        send_request(ACT_CONVERT, 10000, 1'b0);
    endtask

    task automatic test_clamp_random();
        set_mode(MODE_CLAMP);
        repeat (200)
            send_request(($urandom_range(0, 9) < 3) ? ACT_MEASURE : ACT_CONVERT,
                         rand_voxel(), 1'($urandom_range(0, 1)));
    endtask

    task automatic test_stretch_volumes();
        set_mode(MODE_STRETCH);
        repeat (30)
            random_volume();
    endtask

    // Mode flips with loose traffic; ranges built in clamp carry into stretch
    task automatic test_mode_changes();
        for (int ph = 0; ph < 4; ph++) begin
            set_mode((ph % 2) ? MODE_STRETCH : MODE_CLAMP);
            repeat (25)
                send_request(($urandom_range(0, 9) < 4) ? ACT_MEASURE : ACT_CONVERT,
                             rand_voxel(), $urandom_range(0, 3) == 0);
        end
    endtask

    // Sender stops mid-stream until every pixel is out, then carries on
    task automatic test_drain_pause();
        repeat (2)
            random_volume();
        wait_drained();
        repeat (2)
            random_volume();
    endtask

    // Last stretch of the run at full rate on both sides
    task automatic test_steady_stream();
        idle_on = 1'b0;
        repeat (8)
            random_volume();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n  = 1'b0;
        i_valid  = 1'b0;
        i_action = ACT_MEASURE;
        i_value  = '0;
        i_first  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        mode_q   = MODE_CLAMP;
        range_lo = '0;
        range_hi = '0;
        idle_on  = 1'b1;
        fails    = 0;
        hang_cnt = 0;
        n_measure = 0;
        n_clamp   = 0;
        n_stretch = 0;
        n_checked = 0;
        n_mode_writes = 0;

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_stretch_from_reset();
        test_clamp_corners();
        test_stretch_corners();
        test_clamp_random();
        test_stretch_volumes();
        test_mode_changes();
        test_drain_pause();
        test_steady_stream();

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("covered %0d measure, %0d clamp and %0d stretch convert requests",
                 n_measure, n_clamp, n_stretch);
        $display("%0d pixels scored, %0d mode writes, %0d failures",
                 n_checked, n_mode_writes, fails);
        if (fails == 0)
            $display("minmax_normalize_to_byte_core regression: pass");
        else
            $display("minmax_normalize_to_byte_core regression: fail");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/mmnb_pkg.sv
hw/rtl/mmnb_ctrl.sv
hw/rtl/mmnb_dp.sv
hw/rtl/minmax_normalize_to_byte_core.sv
test/minmax_normalize_to_byte_core_test.sv
